[rtl/rfp_pkg.sv]
// ----------------------------------------------------------------------------
// Radar frame parser package
// Shared types and constants of the radar frame parser.
// ----------------------------------------------------------------------------
package rfp_pkg;

   localparam int FRAME_BYTES_DEFAULT = 64;
   localparam int HEAD_DEPTH = 18;
   localparam int DATA_BYTES = 12;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] HDR_FIRST = 8'h53;
   localparam logic [7:0] HDR_SECOND = 8'h59;
   localparam logic [7:0] END_FIRST = 8'h54;
   localparam logic [7:0] END_SECOND = 8'h43;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_SHORT = 3'd1;
   localparam logic [2:0] ST_CHECKSUM = 3'd2;
   localparam logic [2:0] ST_LENGTH = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;

   localparam logic [7:0] CTRL_HUMAN = 8'h80;
   localparam logic [7:0] CTRL_BREATH = 8'h81;
   localparam logic [7:0] CTRL_SLEEP = 8'h84;
   localparam logic [7:0] CTRL_HEART = 8'h85;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] ctrl;
      logic [7:0] cmd;
      logic [15:0] dlen;
      logic [DATA_BYTES-1:0][7:0] data;
   } job_type;

endpackage

[rtl/radar_frame_parser_unit.sv]
// ----------------------------------------------------------------------------
// Radar frame parser
// Parses radar serial frames and emits field updates and a frame status.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle while the two-entry job queue has room.
// Results leave one per cycle unless rsp_ready stalls; a frame's job passes
// the queue and back-end output register; N field updates give N+1 results.
// Synchronous active-high reset clears framing state, held rates and queue.
module radar_frame_parser_unit #(
   parameter int FRAME_BYTES = rfp_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [7:0] req_rx_byte,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_result_kind,
   output logic [5:0] rsp_field_id,
   output logic signed [16:0] rsp_field_value,
   output logic [2:0] rsp_frame_status,
   output logic [7:0] rsp_frame_ctrl,
   output logic [7:0] rsp_frame_cmd,
   output logic rsp_heart_ok,
   output logic rsp_breath_ok,
   output logic rsp_last
);
   import rfp_pkg::*;

   job_type push_job, pop_job;
   logic push, push_ready, pop, pop_valid;

   rfp_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_rx_byte(req_rx_byte),
      .q_ready(push_ready), .q_push(push), .q_job(push_job)
   );

   rfp_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_job(push_job), .push_ready(push_ready),
      .pop(pop), .pop_valid(pop_valid), .pop_job(pop_job)
   );

   rfp_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(pop_valid), .q_job(pop_job), .q_pop(pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_kind(rsp_result_kind), .rsp_field_id(rsp_field_id),
      .rsp_field_value(rsp_field_value), .rsp_frame_status(rsp_frame_status),
      .rsp_frame_ctrl(rsp_frame_ctrl), .rsp_frame_cmd(rsp_frame_cmd),
      .rsp_heart_ok(rsp_heart_ok), .rsp_breath_ok(rsp_breath_ok),
      .rsp_last(rsp_last)
   );

endmodule

[rtl/rfp_front.sv]
// ----------------------------------------------------------------------------
// Radar frame parser front end
// Tracks framing, checksum and length per byte and issues one job per frame.
// ----------------------------------------------------------------------------
module rfp_front #(
   parameter int FRAME_BYTES = rfp_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic q_ready,
   output logic q_push,
   output rfp_pkg::job_type q_job
);
   import rfp_pkg::*;

   localparam int CW = $clog2(FRAME_BYTES + 1);

   logic [7:0] prev_ff, prev_in;
   logic inside_ff, inside_in;
   logic [CW-1:0] count_ff, count_in;
   logic [HEAD_DEPTH-1:0][7:0] head_ff, head_in;
   logic [2:0][7:0] recent_ff, recent_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] c;
   logic [7:0] calc;
   logic [CW-1:0] count_next;
   logic [16:0] need;
   logic accept;

   assign req_ready = q_ready;
   assign accept = req_valid && q_ready;
   assign c = req_rx_byte;
   assign count_next = count_ff + CW'(1);
   assign calc = sum_in - recent_in[0] - recent_in[1] - recent_in[2];
   assign need = 17'(head_in[4]) * 17'd256 + 17'(head_in[5]) + 17'd9;

   always_comb begin
      prev_in = prev_ff;
      inside_in = inside_ff;
      count_in = count_ff;
      head_in = head_ff;
      recent_in = recent_ff;
      sum_in = sum_ff;
      q_push = 1'b0;
      q_job.status = ST_OK;
      if (accept) begin
         prev_in = c;
         if (!inside_ff) begin
            if (prev_ff == HDR_FIRST && c == HDR_SECOND) begin
               inside_in = 1'b1;
               count_in = CW'(2);
               sum_in = HDR_FIRST + HDR_SECOND;
               recent_in[0] = 8'h00;
               recent_in[1] = HDR_FIRST;
               recent_in[2] = HDR_SECOND;
               head_in[0] = HDR_FIRST;
               head_in[1] = HDR_SECOND;
            end
         end else if (count_ff < CW'(FRAME_BYTES)) begin
            for (int i = 0; i < HEAD_DEPTH; i++) begin
               if (count_ff == CW'(i)) begin
                  head_in[i] = c;
               end
            end
            recent_in[0] = recent_ff[1];
            recent_in[1] = recent_ff[2];
            recent_in[2] = c;
            sum_in = sum_ff + c;
            count_in = count_next;
            if (recent_ff[2] == END_FIRST && c == END_SECOND) begin
               q_push = 1'b1;
               inside_in = 1'b0;
               count_in = '0;
               if (count_next < CW'(8)) begin
                  q_job.status = ST_SHORT;
               end else if (calc != recent_in[0]) begin
                  q_job.status = ST_CHECKSUM;
               end else if (need > 17'(count_next)) begin
                  q_job.status = ST_LENGTH;
               end
            end
         end else begin
            q_push = 1'b1;
            q_job.status = ST_OVERFLOW;
            inside_in = 1'b0;
            count_in = '0;
         end
      end
      q_job.ctrl = head_in[2];
      q_job.cmd = head_in[3];
      q_job.dlen = {head_in[4], head_in[5]};
      for (int i = 0; i < DATA_BYTES; i++) begin
         q_job.data[i] = head_in[6 + i];
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      recent_ff <= recent_in;
      if (reset) begin
         prev_ff <= '0;
         inside_ff <= 1'b0;
         count_ff <= '0;
         sum_ff <= '0;
      end else begin
         prev_ff <= prev_in;
         inside_ff <= inside_in;
         count_ff <= count_in;
         sum_ff <= sum_in;
      end
   end

endmodule

[rtl/rfp_queue.sv]
// ----------------------------------------------------------------------------
// Radar frame parser job queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module rfp_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  rfp_pkg::job_type push_job,
   output logic push_ready,
   input  logic pop,
   output logic pop_valid,
   output rfp_pkg::job_type pop_job
);
   import rfp_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   job_type entry_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0] fill_ff, fill_in;
   logic do_push, do_pop;

   assign push_ready = fill_ff != (PW + 1)'(QUEUE_DEPTH);
   assign pop_valid = fill_ff != '0;
   assign pop_job = entry_ff[rd_ff];
   assign do_push = push && push_ready;
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (PW + 1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (PW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_job;
      end
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

[rtl/rfp_back.sv]
// ----------------------------------------------------------------------------
// Radar frame parser back end
// Steps through the field updates of a job and closes it with its status.
// ----------------------------------------------------------------------------
module rfp_back (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   input  rfp_pkg::job_type q_job,
   output logic q_pop,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_result_kind,
   output logic [5:0] rsp_field_id,
   output logic signed [16:0] rsp_field_value,
   output logic [2:0] rsp_frame_status,
   output logic [7:0] rsp_frame_ctrl,
   output logic [7:0] rsp_frame_cmd,
   output logic rsp_heart_ok,
   output logic rsp_breath_ok,
   output logic rsp_last
);
   import rfp_pkg::*;

   typedef struct packed {
      logic [5:0] id;
      logic [16:0] value;
   } field_type;

   function automatic logic [3:0] plan_count(logic [7:0] ctrl, logic [7:0] cmd,
                                             logic [15:0] dlen);
      logic [3:0] n;
      n = 4'd0;
      unique case (ctrl)
         CTRL_HUMAN: begin
            if (cmd >= 8'd1 && cmd <= 8'd3 && dlen >= 16'd1) n = 4'd1;
            else if (cmd == 8'd4 && dlen >= 16'd2) n = 4'd1;
            else if (cmd == 8'd5 && dlen >= 16'd6) n = 4'd3;
         end
         CTRL_BREATH: begin
            if ((cmd == 8'd1 || cmd == 8'd2) && dlen >= 16'd1) n = 4'd1;
            else if (cmd == 8'd5 && dlen >= 16'd5) n = 4'd5;
         end
         CTRL_HEART: begin
            if (cmd == 8'd2 && dlen >= 16'd1) n = 4'd1;
            else if (cmd == 8'd5 && dlen >= 16'd5) n = 4'd5;
         end
         CTRL_SLEEP: begin
            unique case (cmd) inside
               8'h01, 8'h81, 8'h06, 8'h0E, 8'h8E, 8'h10, 8'h90, 8'h11, 8'h91, 8'h12,
               8'h92: if (dlen >= 16'd1) n = 4'd1;
               8'h03, 8'h83, 8'h04, 8'h84, 8'h05, 8'h85, 8'h86:
                  if (dlen >= 16'd2) n = 4'd1;
               8'h0C, 8'h8D: if (dlen >= 16'd8) n = 4'd8;
               8'h0D, 8'h8F: if (dlen >= 16'd12) n = 4'd11;
               default: n = 4'd0;
            endcase
         end
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic field_type field_at(logic [7:0] ctrl, logic [7:0] cmd,
                                          logic [3:0] k,
                                          logic [DATA_BYTES-1:0][7:0] d);
      field_type f;
      logic [7:0] dk, dk1;
      logic [15:0] w;
      dk = d[k];
      dk1 = d[k + 4'd1];
      w = {d[{k[2:0], 1'b0}], d[{k[2:0], 1'b1}]};
      f.id = 6'd0;
      f.value = {9'd0, d[0]};
      unique case (ctrl)
         CTRL_HUMAN: begin
            if (cmd == 8'd4) begin
               f.id = 6'd3;
               f.value = {1'b0, d[0], d[1]};
            end else if (cmd == 8'd5) begin
               f.id = 6'd4 + 6'(k);
               f.value = w[15] ? -{2'b00, w[14:0]} : {2'b00, w[14:0]};
            end else begin
               f.id = 6'(cmd - 8'd1);
            end
         end
         CTRL_BREATH: begin
            if (cmd == 8'd5) begin
               f.id = 6'd9 + 6'(k);
               f.value = {9'd0, dk} - 17'd128;
            end else begin
               f.id = (cmd == 8'd1) ? 6'd7 : 6'd8;
            end
         end
         CTRL_HEART: begin
            if (cmd == 8'd5) begin
               f.id = 6'd15 + 6'(k);
               f.value = {9'd0, dk} - 17'd128;
            end else begin
               f.id = 6'd14;
            end
         end
         CTRL_SLEEP: begin
            unique case (cmd) inside
               8'h01, 8'h81: f.id = 6'd20;
               8'h03, 8'h83: begin f.id = 6'd21; f.value = {1'b0, d[0], d[1]}; end
               8'h04, 8'h84: begin f.id = 6'd22; f.value = {1'b0, d[0], d[1]}; end
               8'h05, 8'h85: begin f.id = 6'd23; f.value = {1'b0, d[0], d[1]}; end
               8'h06, 8'h86: f.id = 6'd24;
               8'h0C, 8'h8D: begin
                  f.id = (k == 4'd0) ? 6'd0 : 6'd24 + 6'(k);
                  f.value = {9'd0, dk};
               end
               8'h0D, 8'h8F: begin
                  f.value = {9'd0, dk1};
                  case (k)
                     4'd0: begin f.id = 6'd24; f.value = {9'd0, d[0]}; end
                     4'd1: begin f.id = 6'd32; f.value = {1'b0, d[1], d[2]}; end
                     4'd6: f.id = 6'd37;
                     4'd7: f.id = 6'd28;
                     4'd8: f.id = 6'd26;
                     4'd9: f.id = 6'd27;
                     4'd10: f.id = 6'd31;
                     default: f.id = 6'd31 + 6'(k);
                  endcase
               end
               8'h0E, 8'h8E: f.id = 6'd38;
               8'h10, 8'h90: f.id = 6'd39;
               8'h11, 8'h91: f.id = 6'd40;
               8'h12, 8'h92: f.id = 6'd41;
               default: f.id = 6'd0;
            endcase
         end
         default: f.id = 6'd0;
      endcase
      return f;
   endfunction

   logic [3:0] step_ff, step_in;
   logic [7:0] heart_ff, heart_in, breath_ff, breath_in;
   logic valid_ff, valid_in;
   logic kind_ff, kind_in;
   logic [5:0] id_ff, id_in;
   logic [16:0] value_ff, value_in;
   logic [2:0] status_ff, status_in;
   logic [7:0] ctrl_ff, ctrl_in, cmd_ff, cmd_in;
   logic hok_ff, hok_in, bok_ff, bok_in, last_ff, last_in;
   logic [3:0] n;
   logic slot_free;
   field_type f;

   assign n = (q_job.status == ST_OK) ? plan_count(q_job.ctrl, q_job.cmd, q_job.dlen) : 4'd0;
   assign f = field_at(q_job.ctrl, q_job.cmd, step_ff, q_job.data);
   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      step_in = step_ff;
      heart_in = heart_ff;
      breath_in = breath_ff;
      valid_in = valid_ff && !rsp_ready;
      kind_in = kind_ff;
      id_in = id_ff;
      value_in = value_ff;
      status_in = status_ff;
      ctrl_in = ctrl_ff;
      cmd_in = cmd_ff;
      hok_in = hok_ff;
      bok_in = bok_ff;
      last_in = last_ff;
      q_pop = 1'b0;
      if (slot_free && q_valid) begin
         valid_in = 1'b1;
         ctrl_in = q_job.ctrl;
         cmd_in = q_job.cmd;
         if (step_ff < n) begin
            step_in = step_ff + 4'd1;
            kind_in = 1'b0;
            id_in = f.id;
            value_in = f.value;
            status_in = ST_OK;
            hok_in = 1'b0;
            bok_in = 1'b0;
            last_in = 1'b0;
            if (q_job.cmd == 8'd2 && q_job.ctrl == CTRL_BREATH) breath_in = q_job.data[0];
            if (q_job.cmd == 8'd2 && q_job.ctrl == CTRL_HEART) heart_in = q_job.data[0];
         end else begin
            step_in = 4'd0;
            q_pop = 1'b1;
            kind_in = 1'b1;
            id_in = 6'd0;
            value_in = 17'd0;
            status_in = q_job.status;
            hok_in = heart_ff != 8'd0 && heart_ff < 8'd200;
            bok_in = breath_ff >= 8'd1 && breath_ff <= 8'd60;
            last_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      id_ff <= id_in;
      value_ff <= value_in;
      status_ff <= status_in;
      ctrl_ff <= ctrl_in;
      cmd_ff <= cmd_in;
      hok_ff <= hok_in;
      bok_ff <= bok_in;
      last_ff <= last_in;
      if (reset) begin
         step_ff <= '0;
         heart_ff <= '0;
         breath_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         heart_ff <= heart_in;
         breath_ff <= breath_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_field_id = id_ff;
   assign rsp_field_value = value_ff;
   assign rsp_frame_status = status_ff;
   assign rsp_frame_ctrl = ctrl_ff;
   assign rsp_frame_cmd = cmd_ff;
   assign rsp_heart_ok = hok_ff;
   assign rsp_breath_ok = bok_ff;
   assign rsp_last = last_ff;

endmodule
